[hw/rtl/wpsteer_pkg.sv]
package wpsteer_pkg;

    localparam int IDX_W      = 5;
    localparam int MOD_STEPS  = 12;
    localparam int DEG_WRAP   = 360;
    localparam int ATAN_TAB_N = 24;

    localparam logic signed [33:0] ANG_PI      = 34'sh0_8000_0000;
    localparam logic signed [33:0] ANG_HALF_PI = 34'sh0_4000_0000;
    localparam logic signed [33:0] CORDIC_K    = 34'sd652032874;
    localparam logic signed [16:0] BEAR_MAX    = 17'sd46080;

    localparam logic [1:0] REG_PROP_GAIN = 2'd0;
    localparam logic [1:0] REG_DIFF_GAIN = 2'd1;
    localparam logic [1:0] REG_X_TOL     = 2'd2;
    localparam logic [1:0] REG_Y_TOL     = 2'd3;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_ROT,
        OP_MUL,
        OP_ACC,
        OP_ATAN_INIT,
        OP_ATAN,
        OP_BEAR_MUL,
        OP_BEAR_CLAMP,
        OP_PD_P,
        OP_PD_D,
        OP_PD_SUM,
        OP_TRUNC,
        OP_MOD,
        OP_OUT
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROT,
        ST_MUL,
        ST_ACC,
        ST_ATAN_INIT,
        ST_ATAN,
        ST_BEAR_MUL,
        ST_BEAR_CLAMP,
        ST_PD_P,
        ST_PD_D,
        ST_PD_SUM,
        ST_TRUNC,
        ST_MOD,
        ST_OUT
    } state_t;

    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] idx;
    } dp_cmd_t;

    function automatic logic signed [33:0] atan_entry(input logic [IDX_W-1:0] i);
        logic signed [33:0] v;
        case (i)
            5'd0:    v = 34'sd536870912;
            5'd1:    v = 34'sd316933406;
            5'd2:    v = 34'sd167458907;
            5'd3:    v = 34'sd85004756;
            5'd4:    v = 34'sd42667331;
            5'd5:    v = 34'sd21354465;
            5'd6:    v = 34'sd10679838;
            5'd7:    v = 34'sd5340245;
            5'd8:    v = 34'sd2670163;
            5'd9:    v = 34'sd1335087;
            5'd10:   v = 34'sd667544;
            5'd11:   v = 34'sd333772;
            5'd12:   v = 34'sd166886;
            5'd13:   v = 34'sd83443;
            5'd14:   v = 34'sd41722;
            5'd15:   v = 34'sd20861;
            5'd16:   v = 34'sd10430;
            5'd17:   v = 34'sd5215;
            5'd18:   v = 34'sd2608;
            5'd19:   v = 34'sd1304;
            5'd20:   v = 34'sd652;
            5'd21:   v = 34'sd326;
            5'd22:   v = 34'sd163;
            5'd23:   v = 34'sd81;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

endpackage

[hw/rtl/waypoint_heading_pd_steer.sv]
// Waypoint heading PD steering controller.
// Input stream s_axis carries one pose/goal word per control tick; the
// output stream m_axis returns one steering word per input word, in order.
// Each word is worked one at a time: load, CORDIC_STEPS rotation steps for
// cos/sin of the yaw, multiply/accumulate pairs on the shared multiplier for
// the frame offset, a setup step and CORDIC_STEPS vectoring steps for the
// bearing, then bearing multiply, clamp, P term, D term, sum and truncate for
// the bearing scale and PD law, twelve restoring steps for the remainder by
// 360, then the output load. s_axis_tready is high only while no word is in
// work, so a new word is not taken until the last one has reached the output
// register.
// The finished word sits in the output register; the next input is taken
// while it waits. If m_axis_tready stays low, the following word holds in
// its final step until the register empties.
// Reset clears the gains and tolerances to their defaults, the stored
// bearing and arrival flag to zero, and empties the output register.
// Write cfg_we/cfg_addr/cfg_wdata only while the block is idle.
module waypoint_heading_pd_steer
    import wpsteer_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [111:0] s_axis_tdata,  // pose_x, pose_y, pose_yaw, goal_x, goal_y
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [15:0]  m_axis_tdata,  // steer_cmd, cmd_valid, arrived, zero pad
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [19:0]  cfg_wdata
);

    dp_cmd_t           cmd;
    logic signed [9:0] steer_cmd;
    logic              cmd_valid;
    logic              arrived;

    wpsteer_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    wpsteer_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .pose_x    (s_axis_tdata[23:0]),
        .pose_y    (s_axis_tdata[47:24]),
        .pose_yaw  (s_axis_tdata[63:48]),
        .goal_x    (s_axis_tdata[87:64]),
        .goal_y    (s_axis_tdata[111:88]),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .steer_cmd (steer_cmd),
        .cmd_valid (cmd_valid),
        .arrived   (arrived)
    );

    assign m_axis_tdata = {4'd0, arrived, cmd_valid, steer_cmd};

endmodule

[hw/rtl/wpsteer_ctrl.sv]
module wpsteer_ctrl
    import wpsteer_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output dp_cmd_t cmd
);

    localparam logic [IDX_W-1:0] ROT_LAST = IDX_W'(CORDIC_STEPS - 1);
    localparam logic [IDX_W-1:0] MUL_LAST = IDX_W'(3);
    localparam logic [IDX_W-1:0] MOD_LAST = IDX_W'(MOD_STEPS - 1);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (in_valid)
                    state_next = ST_ROT;
            end
            ST_ROT:
            begin
                if (cnt_reg == ROT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_MUL;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_MUL:
                state_next = ST_ACC;
            ST_ACC:
            begin
                if (cnt_reg == MUL_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_ATAN_INIT;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_ATAN_INIT:
                state_next = ST_ATAN;
            ST_ATAN:
            begin
                if (cnt_reg == ROT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_BEAR_MUL;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_BEAR_MUL:   state_next = ST_BEAR_CLAMP;
            ST_BEAR_CLAMP: state_next = ST_PD_P;
            ST_PD_P:       state_next = ST_PD_D;
            ST_PD_D:       state_next = ST_PD_SUM;
            ST_PD_SUM:     state_next = ST_TRUNC;
            ST_TRUNC:
            begin
                cnt_next   = '0;
                state_next = ST_MOD;
            end
            ST_MOD:
            begin
                if (cnt_reg == MOD_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_OUT;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_OUT:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.idx        = cnt_reg;
        cmd.op         = OP_IDLE;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    cmd.op = OP_LOAD;
            end
            ST_ROT:        cmd.op = OP_ROT;
            ST_MUL:        cmd.op = OP_MUL;
            ST_ACC:        cmd.op = OP_ACC;
            ST_ATAN_INIT:  cmd.op = OP_ATAN_INIT;
            ST_ATAN:       cmd.op = OP_ATAN;
            ST_BEAR_MUL:   cmd.op = OP_BEAR_MUL;
            ST_BEAR_CLAMP: cmd.op = OP_BEAR_CLAMP;
            ST_PD_P:       cmd.op = OP_PD_P;
            ST_PD_D:       cmd.op = OP_PD_D;
            ST_PD_SUM:     cmd.op = OP_PD_SUM;
            ST_TRUNC:      cmd.op = OP_TRUNC;
            ST_MOD:        cmd.op = OP_MOD;
            ST_OUT:
            begin
                if (slot_free)
                begin
                    cmd.op         = OP_OUT;
                    out_valid_next = 1'b1;
                end
            end
            default:       cmd.op = OP_IDLE;
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

[hw/rtl/wpsteer_dp.sv]
module wpsteer_dp
    import wpsteer_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             cmd,
    input  logic signed [23:0]  pose_x,
    input  logic signed [23:0]  pose_y,
    input  logic signed [15:0]  pose_yaw,
    input  logic signed [23:0]  goal_x,
    input  logic signed [23:0]  goal_y,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_addr,
    input  logic [19:0]         cfg_wdata,
    output logic signed [9:0]   steer_cmd,
    output logic                cmd_valid,
    output logic                arrived
);

    logic [15:0] prop_gain_reg, diff_gain_reg;
    logic [19:0] x_tol_reg, y_tol_reg;
    logic signed [16:0] last_reg;
    logic               arr_flag_reg;

    logic signed [24:0] dx_reg, dy_reg;
    logic signed [33:0] rx_reg, ry_reg, rz_reg;
    logic               fold_reg;
    logic signed [58:0] prod_reg;
    logic signed [59:0] acc_x_reg, acc_y_reg;
    logic signed [45:0] ax_reg, ay_reg;
    logic signed [33:0] az_reg;
    logic               zero_reg, arr_reg;
    logic signed [16:0] bear_reg;
    logic signed [36:0] u_reg;
    logic [20:0]        rem_reg;
    logic               neg_reg;
    logic signed [9:0]  steer_reg;
    logic               cmdv_reg, arr_out_reg;

    logic signed [33:0] yaw_ang, yaw_fold, cos_v, sin_v, mul_b, atan_v;
    logic               yaw_folded;
    logic signed [24:0] mul_a;
    logic signed [27:0] fx, fy;
    logic signed [45:0] x0, y0;
    logic signed [59:0] bear_t;
    logic signed [28:0] bear_w;
    logic signed [16:0] bear_c;
    logic signed [17:0] bear_d;
    logic signed [36:0] u_abs;
    logic [20:0]        mod_sub;
    logic [IDX_W-1:0]   mod_k;
    logic [8:0]         rem9;

    assign yaw_ang    = {{2{pose_yaw[15]}}, pose_yaw, 16'd0};
    assign yaw_folded = (yaw_ang > ANG_HALF_PI) || (yaw_ang < -ANG_HALF_PI);
    assign yaw_fold   = (yaw_ang > ANG_HALF_PI) ? yaw_ang - ANG_PI :
                        (yaw_ang < -ANG_HALF_PI) ? yaw_ang + ANG_PI : yaw_ang;
    assign atan_v     = atan_entry(cmd.idx);

    assign cos_v = fold_reg ? -rx_reg : rx_reg;
    assign sin_v = fold_reg ? -ry_reg : ry_reg;
    assign mul_a = (cmd.idx[1:0] == 2'd1 || cmd.idx[1:0] == 2'd2) ? dy_reg : dx_reg;
    assign mul_b = cmd.idx[0] ? sin_v : cos_v;

    assign fx = acc_x_reg[57:30];
    assign fy = acc_y_reg[57:30];
    assign x0 = {{2{fx[27]}}, fx, 16'd0};
    assign y0 = {{2{fy[27]}}, fy, 16'd0};

    assign bear_t = {prod_reg[58], prod_reg} + 60'sh0_0000_4000_0000;
    assign bear_w = bear_t[59:31];
    assign bear_c = (bear_w > 29'(BEAR_MAX)) ? BEAR_MAX :
                    (bear_w < -29'(BEAR_MAX)) ? -BEAR_MAX : bear_w[16:0];
    assign bear_d = {bear_reg[16], bear_reg} - {last_reg[16], last_reg};

    assign u_abs   = u_reg[36] ? -u_reg : u_reg;
    assign mod_k   = IDX_W'(MOD_STEPS - 1) - cmd.idx;
    assign mod_sub = 21'(DEG_WRAP) << mod_k;
    assign rem9    = rem_reg[8:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg <= 16'd230;
            diff_gain_reg <= 16'd768;
            x_tol_reg     <= 20'd102;
            y_tol_reg     <= 20'd307;
            last_reg      <= '0;
            arr_flag_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_PROP_GAIN: prop_gain_reg <= cfg_wdata[15:0];
                    REG_DIFF_GAIN: diff_gain_reg <= cfg_wdata[15:0];
                    REG_X_TOL:     x_tol_reg     <= cfg_wdata;
                    REG_Y_TOL:     y_tol_reg     <= cfg_wdata;
                    default:       x_tol_reg     <= x_tol_reg;
                endcase
            end
            if (cmd.op == OP_OUT)
            begin
                last_reg     <= bear_reg;
                arr_flag_reg <= arr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                dx_reg   <= {goal_x[23], goal_x} - {pose_x[23], pose_x};
                dy_reg   <= {goal_y[23], goal_y} - {pose_y[23], pose_y};
                rx_reg   <= CORDIC_K;
                ry_reg   <= '0;
                rz_reg   <= yaw_fold;
                fold_reg <= yaw_folded;
            end
            OP_ROT:
            begin
                if (!rz_reg[33])
                begin
                    rx_reg <= rx_reg - (ry_reg >>> cmd.idx);
                    ry_reg <= ry_reg + (rx_reg >>> cmd.idx);
                    rz_reg <= rz_reg - atan_v;
                end
                else
                begin
                    rx_reg <= rx_reg + (ry_reg >>> cmd.idx);
                    ry_reg <= ry_reg - (rx_reg >>> cmd.idx);
                    rz_reg <= rz_reg + atan_v;
                end
            end
            OP_MUL:
                prod_reg <= 59'(mul_a * mul_b);
            OP_ACC:
            begin
                case (cmd.idx[1:0])
                    2'd0:    acc_x_reg <= {prod_reg[58], prod_reg};
                    2'd1:    acc_x_reg <= acc_x_reg + {prod_reg[58], prod_reg};
                    2'd2:    acc_y_reg <= {prod_reg[58], prod_reg};
                    default: acc_y_reg <= acc_y_reg - {prod_reg[58], prod_reg};
                endcase
            end
            OP_ATAN_INIT:
            begin
                zero_reg <= (fx == '0) && (fy == '0);
                arr_reg  <= ($signed({fx[27], fx}) <= $signed({9'd0, x_tol_reg}))
                         && ($signed({fy[27], fy}) <= $signed({9'd0, y_tol_reg}));
                if (fx[27])
                begin
                    ax_reg <= -x0;
                    ay_reg <= -y0;
                    az_reg <= fy[27] ? -ANG_PI : ANG_PI;
                end
                else
                begin
                    ax_reg <= x0;
                    ay_reg <= y0;
                    az_reg <= '0;
                end
            end
            OP_ATAN:
            begin
                if (!ay_reg[45] && ay_reg != '0)
                begin
                    ax_reg <= ax_reg + (ay_reg >>> cmd.idx);
                    ay_reg <= ay_reg - (ax_reg >>> cmd.idx);
                    az_reg <= az_reg + atan_v;
                end
                else
                begin
                    ax_reg <= ax_reg - (ay_reg >>> cmd.idx);
                    ay_reg <= ay_reg + (ax_reg >>> cmd.idx);
                    az_reg <= az_reg - atan_v;
                end
            end
            OP_BEAR_MUL:
                prod_reg <= zero_reg ? '0 : 59'(az_reg * 18'sd46080);
            OP_BEAR_CLAMP:
                bear_reg <= bear_c;
            OP_PD_P:
                prod_reg <= 59'($signed({1'b0, prop_gain_reg}) * bear_reg);
            OP_PD_D:
            begin
                u_reg    <= 37'(prod_reg);
                prod_reg <= 59'($signed({1'b0, diff_gain_reg}) * bear_d);
            end
            OP_PD_SUM:
                u_reg <= u_reg + 37'(prod_reg) + 37'sd32768;
            OP_TRUNC:
            begin
                rem_reg <= {1'b0, u_abs[35:16]};
                neg_reg <= !u_reg[36];
            end
            OP_MOD:
            begin
                if (rem_reg >= mod_sub)
                    rem_reg <= rem_reg - mod_sub;
            end
            OP_OUT:
            begin
                steer_reg   <= neg_reg ? -$signed({1'b0, rem9}) : $signed({1'b0, rem9});
                cmdv_reg    <= !arr_flag_reg;
                arr_out_reg <= arr_reg;
            end
            default:
                steer_reg <= steer_reg;
        endcase
    end

    assign steer_cmd = steer_reg;
    assign cmd_valid = cmdv_reg;
    assign arrived   = arr_out_reg;

endmodule
